// ===== hdl/ipv4p_pkg.sv =====
// Shared types, codes and constants for the IPv4 dotted-string parser.
`default_nettype none

package ipv4p_pkg;

   localparam int MAX_SEG_VALUE = 255;
   localparam int TOP_SHIFT     = 24;
   localparam int MAX_SEG_CHARS = 3;
   localparam int SEG_COUNT     = 4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      ST_OK                = 3'd0,
      ST_TOO_LONG          = 3'd1,
      ST_SPACE_AFTER_DIGIT = 3'd2,
      ST_INVALID           = 3'd3,
      ST_EMPTY             = 3'd4,
      ST_OVER              = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_word_type;

   typedef struct packed {
      logic [31:0] address;
      status_type  status;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]  seg_index;
      logic [1:0]  seg_chars;
      logic        digit_seen;
      logic [9:0]  seg_value;
      logic [31:0] address_acc;
      status_type  error_code;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      seg_index:   3'd0,
      seg_chars:   2'd0,
      digit_seen:  1'b0,
      seg_value:   10'd0,
      address_acc: 32'd0,
      error_code:  ST_OK
   };

endpackage

`default_nettype wire

// ===== hdl/ipv4p_in_reg.sv =====
// Input register stage holding one accepted character word.
`default_nettype none

module ipv4p_in_reg
   import ipv4p_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire req_word_type req_word,
   input  wire logic         take,
   output logic              req_stall,
   output logic              word_valid,
   output req_word_type      word
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         load;

   assign req_stall  = valid_ff && !take;
   assign load       = req_valid && !req_stall;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_word;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ipv4p_parse.sv =====
// Per-character parse step and the running segment/address state.
`default_nettype none

module ipv4p_parse
   import ipv4p_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_word_type word,
   output logic              done,
   output rsp_word_type      result
);

   parse_state_type st_ff;
   parse_state_type st_in;
   parse_state_type nx;
   logic            is_space;
   logic            is_digit;
   logic            is_dot;

   function automatic parse_state_type close_seg(parse_state_type s);
      parse_state_type r;
      logic [4:0]      sh;
      r  = s;
      sh = 5'(TOP_SHIFT) - {s.seg_index[1:0], 3'b000};
      if (s.seg_chars == 2'd0) begin
         r.error_code = ST_EMPTY;
      end else if (s.seg_value > 10'(MAX_SEG_VALUE)) begin
         r.error_code = ST_OVER;
      end else begin
         r.address_acc = s.address_acc | (32'(s.seg_value[7:0]) << sh);
         r.seg_index   = s.seg_index + 3'd1;
      end
      r.seg_chars  = 2'd0;
      r.digit_seen = 1'b0;
      r.seg_value  = 10'd0;
      return r;
   endfunction

   function automatic logic active(parse_state_type s);
      return (s.error_code == ST_OK) && (s.seg_index < 3'(SEG_COUNT));
   endfunction

   assign is_space = (word.char_code == CHAR_SPACE);
   assign is_digit = (word.char_code >= CHAR_ZERO) && (word.char_code <= CHAR_NINE);
   assign is_dot   = (word.char_code == CHAR_DOT);
   assign done     = step && word.last_char;

   always_comb begin
      nx = st_ff;
      if (active(st_ff)) begin
         if (is_dot) begin
            nx = close_seg(st_ff);
         end else if (st_ff.seg_chars >= 2'(MAX_SEG_CHARS)) begin
            nx.error_code = ST_TOO_LONG;
         end else if (st_ff.digit_seen && is_space) begin
            nx.error_code = ST_SPACE_AFTER_DIGIT;
         end else if (!is_space && !is_digit) begin
            nx.error_code = ST_INVALID;
         end else begin
            if (is_digit) begin
               nx.seg_value  = (st_ff.seg_value << 3) + (st_ff.seg_value << 1)
                             + 10'(word.char_code[3:0]);
               nx.digit_seen = 1'b1;
            end
            nx.seg_chars = st_ff.seg_chars + 2'd1;
         end
      end
      if (word.last_char && active(nx)) begin
         nx = close_seg(nx);
         if (active(nx)) begin
            nx.error_code = ST_EMPTY;
         end
      end
   end

   always_comb begin
      result.status  = nx.error_code;
      result.address = (nx.error_code == ST_OK) ? nx.address_acc : 32'd0;
   end

   always_comb begin
      if (done) begin
         st_in = PARSE_STATE_RESET;
      end else if (step) begin
         st_in = nx;
      end else begin
         st_in = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= PARSE_STATE_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ipv4_dotted_string_parser_core.sv =====
// Top level of the IPv4 dotted-string parser with the result register.
// Takes an IPv4 dotted-quad string one ASCII character per word, the final
// character flagged by last_char, and returns one word per string carrying
// the 32-bit address (first segment in bits 31..24, zero on error) and a
// status code. One character is accepted every cycle; each passes through
// the input register, then a parse step that updates the segment state,
// and the result is registered in the output register when the final
// character takes its parse step. Throughput is set by that parse step;
// only a stalled result whose slot is needed by a final character holds
// the input side.
`default_nettype none

module ipv4_dotted_string_parser_core
   import ipv4p_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic         in_valid;
   req_word_type in_word;
   logic         out_free;
   logic         take;
   logic         step_done;
   rsp_word_type step_result;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = in_valid && (!in_word.last_char || out_free);

   ipv4p_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .take       (take),
      .req_stall  (req_stall),
      .word_valid (in_valid),
      .word       (in_word)
   );

   ipv4p_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .word   (in_word),
      .done   (step_done),
      .result (step_result)
   );

   always_comb begin
      if (step_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_done) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a finished string never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step_done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   // error results carry a zero address
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != ST_OK) |-> (rsp_word.address == 32'd0))
      else $error("nonzero address on error status");

   // input side only stalls with a word held that cannot advance
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid && in_word.last_char && rsp_valid_ff && rsp_stall))
      else $error("input stalled without cause");

   // a result is valid in the cycle after a final character step
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      step_done |=> rsp_valid)
      else $error("result missing after final character");

endmodule

`default_nettype wire

// ===== dv/ipv4_dotted_string_parser_core_test.sv =====
// Self-checking testbench for the IPv4 dotted-string parser core.
`timescale 1ns / 1ps

module ipv4_dotted_string_parser_core_test
   import ipv4p_pkg::*;
;

   localparam int DIR_ROWS    = 24;
   localparam int RAND_CHARS  = 1000;
   localparam int TAIL_CYCLES = 20;

   typedef struct {
      string       text;
      int          nul_at;
      bit          pinned;
      logic [31:0] address;
      status_type  status;
   } dir_row_type;

   typedef struct {
      req_word_type word;
      bit           pinned;
      rsp_word_type pinned_rsp;
   } char_item_type;

   // pinned rows carry the result typed in; the rest go through the predictor
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{"0.0.0.0",         -1, 1'b1, 32'h0000_0000, ST_OK},
      '{"255.255.255.255", -1, 1'b1, 32'hFFFF_FFFF, ST_OK},
      '{"  1.  2.  3.  4", -1, 1'b0, 32'h0,         ST_OK},
      '{"   .1.2.3",       -1, 1'b0, 32'h0,         ST_OK},
      '{"1.2.3.  ",        -1, 1'b0, 32'h0,         ST_OK},
      '{"007.10.100.99",   -1, 1'b0, 32'h0,         ST_OK},
      '{"10.20.30.40",     -1, 1'b0, 32'h0,         ST_OK},
      '{"1.2.3.4.x\377",   -1, 1'b1, 32'h0102_0304, ST_OK},
      '{"1234.1.1.1",      -1, 1'b1, 32'h0,         ST_TOO_LONG},
      '{"1.2.3.123 ",      -1, 1'b1, 32'h0,         ST_TOO_LONG},
      '{"1.2 .3.4",        -1, 1'b1, 32'h0,         ST_SPACE_AFTER_DIGIT},
      '{"1.a.3.4",         -1, 1'b1, 32'h0,         ST_INVALID},
      '{"1.2Z.3.4",         3, 1'b1, 32'h0,         ST_INVALID},
      '{"1.2.3.\377",      -1, 1'b1, 32'h0,         ST_INVALID},
      '{"9a99999..",       -1, 1'b1, 32'h0,         ST_INVALID},
      '{"1..3.4",          -1, 1'b1, 32'h0,         ST_EMPTY},
      '{".1.2.3",          -1, 1'b1, 32'h0,         ST_EMPTY},
      '{"1.2.3.",          -1, 1'b1, 32'h0,         ST_EMPTY},
      '{"1.2.3",           -1, 1'b1, 32'h0,         ST_EMPTY},
      '{".",               -1, 1'b1, 32'h0,         ST_EMPTY},
      '{"7",               -1, 1'b1, 32'h0,         ST_EMPTY},
      '{"   ",             -1, 1'b1, 32'h0,         ST_EMPTY},
      '{"256.1.1.1",       -1, 1'b1, 32'h0,         ST_OVER},
      '{"1.2.3.999",       -1, 1'b1, 32'h0,         ST_OVER}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   char_item_type char_stream [$];
   rsp_word_type  pending_addresses [$];
   int unsigned   send_pos;
   int unsigned   send_wait;
   int unsigned   stall_left;
   int unsigned   mismatch_count;
   bit            calm;

   // parser state mirror
   logic [2:0]  seg_count;
   logic [1:0]  seg_len;
   logic        seg_digit;
   logic [9:0]  seg_val;
   logic [31:0] addr_acc;
   status_type  first_err;

   ipv4_dotted_string_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic void restart_parse();
      seg_count = '0;
      seg_len   = '0;
      seg_digit = 1'b0;
      seg_val   = '0;
      addr_acc  = '0;
      first_err = ST_OK;
   endfunction

   function automatic void close_segment();
      if (seg_len == 0) begin
         first_err = ST_EMPTY;
      end else if (seg_val > MAX_SEG_VALUE) begin
         first_err = ST_OVER;
      end else begin
         addr_acc  = addr_acc | ({24'd0, seg_val[7:0]} << (TOP_SHIFT - 8 * seg_count[1:0]));
         seg_count = seg_count + 3'd1;
      end
      seg_len   = '0;
      seg_digit = 1'b0;
      seg_val   = '0;
   endfunction

   function automatic void take_char(input logic [7:0] c);
      logic is_space;
      logic is_digit;
      is_space = (c == CHAR_SPACE);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (c == CHAR_DOT) begin
         close_segment();
      end else if (seg_len >= MAX_SEG_CHARS) begin
         first_err = ST_TOO_LONG;
      end else if (seg_digit && is_space) begin
         first_err = ST_SPACE_AFTER_DIGIT;
      end else if (!is_space && !is_digit) begin
         first_err = ST_INVALID;
      end else begin
         if (is_digit) begin
            seg_val   = 10'(seg_val * 10 + (c - CHAR_ZERO));
            seg_digit = 1'b1;
         end
         seg_len = seg_len + 2'd1;
      end
   endfunction

   // returns 1 when the word ends a string, with the expected result
   function automatic bit parse_char(input req_word_type w, output rsp_word_type result);
      result = '0;
      if (first_err == ST_OK && seg_count < SEG_COUNT) take_char(w.char_code);
      if (!w.last_char) return 1'b0;
      if (first_err == ST_OK && seg_count < SEG_COUNT) begin
         close_segment();
         if (first_err == ST_OK && seg_count < SEG_COUNT) first_err = ST_EMPTY;
      end
      result.address = (first_err == ST_OK) ? addr_acc : 32'd0;
      result.status  = first_err;
      restart_parse();
      return 1'b1;
   endfunction

   task automatic push_string(input byte unsigned text[$], input bit pinned,
                              input rsp_word_type pinned_rsp);
      char_item_type item;
      foreach (text[i]) begin
         item.word.char_code = text[i];
         item.word.last_char = (i == text.size() - 1);
         item.pinned         = pinned;
         item.pinned_rsp     = pinned_rsp;
         char_stream.push_back(item);
      end
   endtask

   task automatic push_random_string();
      byte unsigned text[$];
      string        seg;
      int unsigned  val;
      int unsigned  pos;
      text = {};
      if ($urandom_range(0, 99) < 78) begin
         for (int s = 0; s < SEG_COUNT; s++) begin
            if (s != 0) text.push_back(CHAR_DOT);
            if ($urandom_range(0, 15) == 0) begin
               repeat ($urandom_range(1, MAX_SEG_CHARS)) text.push_back(CHAR_SPACE);
            end else begin
               val = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999)
                                                 : $urandom_range(0, 255);
               seg = ($urandom_range(0, 5) == 0) ? $sformatf("%03d", val)
                                                 : $sformatf("%0d", val);
               if ($urandom_range(0, 2) == 0)
                  repeat ($urandom_range(0, MAX_SEG_CHARS - seg.len()))
                     text.push_back(CHAR_SPACE);
               for (int i = 0; i < seg.len(); i++) text.push_back(seg[i]);
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            text.push_back(CHAR_DOT);
            repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
         end
         // broken variant
         if ($urandom_range(0, 5) == 0) begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 3))
               0: text[pos] = 8'($urandom_range(0, 255));
               1: text[pos] = CHAR_DOT;
               2: text[pos] = CHAR_SPACE;
               default: text.insert(pos, 8'(CHAR_ZERO + $urandom_range(0, 9)));
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 9))
               0, 1:    text.push_back(CHAR_DOT);
               2:       text.push_back(CHAR_SPACE);
               3, 4:    text.push_back(8'($urandom_range(0, 255)));
               default: text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            endcase
         end
      end
      push_string(text, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) calm = !calm;
   end

   // input side: drive characters, predict on acceptance
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
         restart_parse();
      end else begin
         if (req_valid && !req_stall) begin
            if (parse_char(req_word, want)) begin
               if (char_stream[send_pos].pinned) want = char_stream[send_pos].pinned_rsp;
               pending_addresses.push_back(want);
            end
            send_pos++;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait != 0 || send_pos >= char_stream.size()) begin
               req_valid <= 1'b0;
               if (send_wait != 0) send_wait--;
            end else begin
               req_valid <= 1'b1;
               req_word  <= char_stream[send_pos].word;
               send_wait = pick_gap();
            end
         end
      end
   end

   // result side: random stall, compare against oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_addresses.size() == 0) begin
               flag_mismatch($sformatf("unexpected result %h/%0d",
                                       rsp_word.address, rsp_word.status));
            end else begin
               want = pending_addresses.pop_front();
               if (rsp_word.address !== want.address)
                  flag_mismatch($sformatf("address %h, want %h",
                                          rsp_word.address, want.address));
               if (rsp_word.status !== want.status)
                  flag_mismatch($sformatf("status %0d, want %0d",
                                          rsp_word.status, want.status));
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      byte unsigned text[$];
      rsp_word_type fixed;
      int unsigned  dir_chars;
      send_pos       = 0;
      mismatch_count = 0;
      calm           = 1'b0;
      foreach (dir_rows[r]) begin
         text = {};
         for (int i = 0; i < dir_rows[r].text.len(); i++)
            text.push_back((i == dir_rows[r].nul_at) ? 8'h00 : dir_rows[r].text[i]);
         fixed.address = dir_rows[r].address;
         fixed.status  = dir_rows[r].status;
         push_string(text, dir_rows[r].pinned, fixed);
      end
      dir_chars = char_stream.size();
      while (char_stream.size() < dir_chars + RAND_CHARS) push_random_string();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (send_pos < char_stream.size() || pending_addresses.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_addresses.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_addresses.size()));
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
